// ----- hw/rtl/bna_pkg.sv -----
// Shared constants, codes and types of the bitmap number allocator.
package bna_pkg;

    localparam int NUM_SERVERS = 16;
    localparam int MAX_SPAN    = 1024;
    localparam int WORD_BITS   = 32;

    localparam int MAP_WORDS = (MAX_SPAN + WORD_BITS - 1) / WORD_BITS;
    localparam int SRV_W     = $clog2(NUM_SERVERS);
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int OFF_W     = WIDX_W + BIT_W;
    localparam int ADDR_W    = SRV_W + WIDX_W;
    localparam int MAP_DEPTH = NUM_SERVERS * MAP_WORDS;

    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_TERM    = 3'd1;
    localparam logic [2:0] OP_REQUEST = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_RESERVE = 3'd4;
    localparam logic [2:0] OP_RESET   = 3'd5;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_SERVER  = 2'd1;
    localparam logic [1:0] ST_RANGE       = 2'd2;
    localparam logic [1:0] ST_UNAVAILABLE = 2'd3;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } scan_res_t;

endpackage

// ----- hw/rtl/bna_req_if.sv -----
// Request channel of the allocator.
interface bna_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [3:0]  server_id;
    logic [15:0] number;
    logic [15:0] lowest;
    logic [15:0] highest;

    modport source (output valid, req_type, server_id, number, lowest, highest, input ready);
    modport sink   (input valid, req_type, server_id, number, lowest, highest, output ready);
endinterface

// ----- hw/rtl/bna_resp_if.sv -----
// Response channel of the allocator.
interface bna_resp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted;

    modport source (output valid, status, granted, input ready);
    modport sink   (input valid, status, granted, output ready);
endinterface

// ----- hw/rtl/bna_map_ram.sv -----
// Simple dual-port RAM holding the usage bitmaps, registered read.
module bna_map_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hw/rtl/bna_word_scan.sv -----
// Finds the lowest free bit of one bitmap word inside the search window.
module bna_word_scan (
    input  logic [bna_pkg::WORD_BITS-1:0] data,
    input  logic [bna_pkg::BIT_W-1:0]     cur_bit,
    input  logic [bna_pkg::BIT_W-1:0]     last_bit,
    input  logic                          first_step,
    input  logic                          last_step,
    input  logic                          at_end,
    output bna_pkg::scan_res_t            res
);
    import bna_pkg::*;

    logic [WORD_BITS-1:0] free;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free[b] = ~data[b];
            if (at_end && (BIT_W'(b) > last_bit))
            begin
                free[b] = 1'b0;
            end
            // first visit starts at the cursor, the wrap-round visit stops short of it
            if (first_step && (BIT_W'(b) < cur_bit))
            begin
                free[b] = 1'b0;
            end
            if (last_step && (BIT_W'(b) >= cur_bit))
            begin
                free[b] = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.found = 1'b0;
        res.pos   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free[b])
            begin
                res.found = 1'b1;
                res.pos   = BIT_W'(b);
            end
        end
    end
endmodule

// ----- hw/rtl/bitmap_number_allocator_unit.sv -----
// Bitmap number allocator: 16 number servers with next-fit allocation, one item
// at a time. After reset a clearing pass sweeps all 512 words of the bitmap
// memory before the first item is taken. Each item is decoded and then handed
// to the output; init of an open server, terminate and errors do no more;
// release and reserve add one read-modify-write of the bitmap RAM; init of a
// closed server and reset add a 32-word clear of that server's map, one word a
// cycle; a request adds a scan of up to ceil(span/32)+1 bitmap words, one word
// a cycle through the shared word scanner.
module bitmap_number_allocator_unit (
    input logic clk,
    input logic rst_n,
    bna_req_if.sink    req,
    bna_resp_if.source resp
);
    import bna_pkg::*;

    localparam logic [2:0] S_CLR_ALL = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DECODE  = 3'd2;
    localparam logic [2:0] S_CLR_SRV = 3'd3;
    localparam logic [2:0] S_SEARCH  = 3'd4;
    localparam logic [2:0] S_MODIFY  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [WIDX_W:0] step_reg, step_next;
    logic [WIDX_W-1:0] iss_reg, iss_next, ev_reg, ev_next;
    logic [OFF_W-1:0] last_off_reg, last_off_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [15:0] res_granted_reg, res_granted_next;

    logic [2:0] op_reg;
    logic [3:0] srv_reg;
    logic [15:0] num_reg, lo_reg, hi_reg;

    logic [15:0] range_low_reg [NUM_SERVERS];
    logic [15:0] range_high_reg [NUM_SERVERS];
    logic [OFF_W-1:0] cursor_reg [NUM_SERVERS];
    logic [7:0] count_reg [NUM_SERVERS];

    logic out_valid_reg;
    logic [1:0] out_status_reg;
    logic [15:0] out_granted_reg;

    logic cnt_we, rng_we, cur_we;
    logic [7:0] cnt_next;
    logic [OFF_W-1:0] cur_next;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [SRV_W-1:0] srv_idx;
    logic srv_ok, is_open;
    logic [15:0] lo_cur, hi_cur;
    logic [7:0] cnt_cur;
    logic [OFF_W-1:0] cursor_cur, dec_last_off, mod_off, found_off;
    logic [WIDX_W-1:0] last_word;
    logic last_step;
    logic [WORD_BITS-1:0] mod_mask;
    scan_res_t scan;

    assign srv_idx    = srv_reg[SRV_W-1:0];
    assign srv_ok     = 32'(srv_reg) < NUM_SERVERS;
    assign lo_cur     = range_low_reg[srv_idx];
    assign hi_cur     = range_high_reg[srv_idx];
    assign cnt_cur    = count_reg[srv_idx];
    assign cursor_cur = cursor_reg[srv_idx];
    assign is_open    = cnt_cur != 8'd0;

    assign dec_last_off = OFF_W'(hi_cur - lo_cur);
    assign mod_off      = OFF_W'(num_reg - lo_cur);
    assign mod_mask     = WORD_BITS'(1) << mod_off[BIT_W-1:0];
    assign last_word    = last_off_reg[OFF_W-1:BIT_W];
    assign last_step    = step_reg == ({1'b0, last_word} + 1'b1);
    assign found_off    = {ev_reg, scan.pos};

    assign req.ready    = state_reg == S_IDLE;
    assign resp.valid   = out_valid_reg;
    assign resp.status  = out_status_reg;
    assign resp.granted = out_granted_reg;

    bna_word_scan u_scan (
        .data       (ram_rdata),
        .cur_bit    (cursor_cur[BIT_W-1:0]),
        .last_bit   (last_off_reg[BIT_W-1:0]),
        .first_step (step_reg == '0),
        .last_step  (last_step),
        .at_end     (ev_reg == last_word),
        .res        (scan)
    );

    bna_map_ram #(
        .DATA_W (WORD_BITS),
        .DEPTH  (MAP_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        step_next        = step_reg;
        iss_next         = iss_reg;
        ev_next          = ev_reg;
        last_off_next    = last_off_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        cnt_we    = 1'b0;
        cnt_next  = cnt_cur;
        rng_we    = 1'b0;
        cur_we    = 1'b0;
        cur_next  = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (state_reg)
            S_CLR_ALL:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == MAP_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_granted_next = '0;
                state_next       = S_DONE;
                if (!srv_ok || op_reg > OP_RESET)
                begin
                    res_status_next = ST_BAD_SERVER;
                end
                else if (op_reg == OP_INIT)
                begin
                    if (hi_reg <= lo_reg || 32'(hi_reg - lo_reg) >= MAX_SPAN)
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else if (is_open)
                    begin
                        cnt_we          = 1'b1;
                        cnt_next        = (cnt_cur == 8'hFF) ? cnt_cur : cnt_cur + 8'd1;
                        res_status_next = ST_OK;
                    end
                    else
                    begin
                        rng_we          = 1'b1;
                        cur_we          = 1'b1;
                        cnt_we          = 1'b1;
                        cnt_next        = 8'd1;
                        clr_next        = '0;
                        res_status_next = ST_OK;
                        state_next      = S_CLR_SRV;
                    end
                end
                else if (!is_open)
                begin
                    res_status_next = ST_BAD_SERVER;
                end
                else
                begin
                    case (op_reg)
                        OP_TERM:
                        begin
                            cnt_we          = 1'b1;
                            cnt_next        = cnt_cur - 8'd1;
                            res_status_next = ST_OK;
                        end
                        OP_RESET:
                        begin
                            cur_we          = 1'b1;
                            clr_next        = '0;
                            res_status_next = ST_OK;
                            state_next      = S_CLR_SRV;
                        end
                        OP_REQUEST:
                        begin
                            ram_re          = 1'b1;
                            ram_raddr       = {srv_idx, cursor_cur[OFF_W-1:BIT_W]};
                            ev_next         = cursor_cur[OFF_W-1:BIT_W];
                            iss_next        = (cursor_cur[OFF_W-1:BIT_W] ==
                                               dec_last_off[OFF_W-1:BIT_W]) ? '0 :
                                              cursor_cur[OFF_W-1:BIT_W] + 1'b1;
                            step_next       = '0;
                            last_off_next   = dec_last_off;
                            res_status_next = ST_UNAVAILABLE;
                            state_next      = S_SEARCH;
                        end
                        default:
                        begin
                            if (num_reg < lo_cur || num_reg > hi_cur)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = {srv_idx, mod_off[OFF_W-1:BIT_W]};
                                state_next = S_MODIFY;
                            end
                        end
                    endcase
                end
            end
            S_CLR_SRV:
            begin
                ram_we    = 1'b1;
                ram_waddr = {srv_idx, clr_reg[WIDX_W-1:0]};
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg[WIDX_W-1:0]) == MAP_WORDS - 1)
                begin
                    state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                if (scan.found)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = {srv_idx, ev_reg};
                    ram_wdata        = ram_rdata | (WORD_BITS'(1) << scan.pos);
                    cur_we           = 1'b1;
                    cur_next         = (found_off == last_off_reg) ? '0 : found_off + 1'b1;
                    res_granted_next = lo_cur + 16'(found_off);
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                end
                else if (last_step)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // keep one word read in flight ahead of the scanner
                    ram_re    = 1'b1;
                    ram_raddr = {srv_idx, iss_reg};
                    ev_next   = iss_reg;
                    iss_next  = (iss_reg == last_word) ? '0 : iss_reg + 1'b1;
                    step_next = step_reg + 1'b1;
                end
            end
            S_MODIFY:
            begin
                state_next      = S_DONE;
                res_status_next = ST_OK;
                ram_waddr       = {srv_idx, mod_off[OFF_W-1:BIT_W]};
                if (op_reg == OP_RELEASE)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~mod_mask;
                end
                else if ((ram_rdata & mod_mask) != '0)
                begin
                    res_status_next = ST_UNAVAILABLE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | mod_mask;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR_ALL;
            clr_reg         <= '0;
            step_reg        <= '0;
            iss_reg         <= '0;
            ev_reg          <= '0;
            last_off_reg    <= '0;
            res_status_reg  <= ST_OK;
            res_granted_reg <= '0;
            out_valid_reg   <= 1'b0;
            for (int s = 0; s < NUM_SERVERS; s++)
            begin
                range_low_reg[s]  <= '0;
                range_high_reg[s] <= '0;
                cursor_reg[s]     <= '0;
                count_reg[s]      <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            step_reg        <= step_next;
            iss_reg         <= iss_next;
            ev_reg          <= ev_next;
            last_off_reg    <= last_off_next;
            res_status_reg  <= res_status_next;
            res_granted_reg <= res_granted_next;
            if (cnt_we)
            begin
                count_reg[srv_idx] <= cnt_next;
            end
            if (rng_we)
            begin
                range_low_reg[srv_idx]  <= lo_reg;
                range_high_reg[srv_idx] <= hi_reg;
            end
            if (cur_we)
            begin
                cursor_reg[srv_idx] <= cur_next;
            end
            if (state_reg == S_DONE && (!out_valid_reg || resp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.req_type;
            srv_reg <= req.server_id;
            num_reg <= req.number;
            lo_reg  <= req.lowest;
            hi_reg  <= req.highest;
        end
        if (state_reg == S_DONE && (!out_valid_reg || resp.ready))
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("item accepted while another is in progress");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.status != ST_OK |-> resp.granted == 16'd0)
        else $error("number granted with an error status");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR_ALL || state_reg == S_CLR_SRV |-> ram_we && !req.ready)
        else $error("bitmap clear not writing or input open");

    a_search_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH && !scan.found && !last_step |-> ram_re)
        else $error("scan stalled without a word read");
endmodule
